@@ sv/afbu_pkg.sv @@
// Package with the shared types and constants of the ALU, flags and branch unit.
package afbu_pkg;

   // Operation codes carried in the kind field of an input transfer.
   typedef enum logic [3:0] {
      KIND_ADC     = 4'd0,
      KIND_SBC     = 4'd1,
      KIND_AND     = 4'd2,
      KIND_ASL_ACC = 4'd3,
      KIND_ASL_MEM = 4'd4,
      KIND_BIT     = 4'd5,
      KIND_BCC     = 4'd6,
      KIND_BCS     = 4'd7,
      KIND_BEQ     = 4'd8,
      KIND_BNE     = 4'd9,
      KIND_BPL     = 4'd10
   } kind_type;

   // Bit positions of the live flags inside the status byte.
   localparam int FLAG_C_BIT = 0;
   localparam int FLAG_Z_BIT = 1;
   localparam int FLAG_V_BIT = 6;
   localparam int FLAG_N_BIT = 7;

   // Branch penalties reported in extra_cycles.
   localparam logic [1:0] EXTRA_NONE       = 2'd0;
   localparam logic [1:0] EXTRA_SAME_PAGE  = 2'd1;
   localparam logic [1:0] EXTRA_CROSS_PAGE = 2'd2;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  operand;
      logic [15:0] next_pc;
      logic [15:0] target_address;
   } req_type;

   typedef struct packed {
      logic [7:0]  accumulator_out;
      logic [7:0]  status_out;
      logic [15:0] new_pc;
      logic        write_enable;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic [1:0]  extra_cycles;
   } rsp_type;

   // The four status flags that the unit keeps; all other status bits read as zero.
   typedef struct packed {
      logic n;
      logic v;
      logic z;
      logic c;
   } flags_type;

   function automatic logic [7:0] status_byte(input flags_type f);
      logic [7:0] s;
      s = 8'h00;
      s[FLAG_C_BIT] = f.c;
      s[FLAG_Z_BIT] = f.z;
      s[FLAG_V_BIT] = f.v;
      s[FLAG_N_BIT] = f.n;
      return s;
   endfunction

endpackage

@@ sv/afbu_exec.sv @@
// Combinational execute logic: ALU, flag update and branch resolution for one item.
module afbu_exec
   import afbu_pkg::*;
(
   input  req_type    item,
   input  logic [7:0] acc,
   input  flags_type  flags,
   output logic [7:0] acc_next,
   output flags_type  flags_next,
   output rsp_type    result
);

   logic [7:0]  addend;
   logic [8:0]  sum;
   logic [7:0]  shifted;
   logic [15:0] offset;
   logic [15:0] target;
   logic        is_branch;
   logic        take;

   // SBC is ADC of the inverted operand; carry acts as not-borrow.
   assign addend  = (kind_type'(item.kind) == KIND_SBC) ? ~item.operand : item.operand;
   assign sum     = {1'b0, acc} + {1'b0, addend} + {8'd0, flags.c};
   assign shifted = (kind_type'(item.kind) == KIND_ASL_MEM) ? {item.operand[6:0], 1'b0}
                                                             : {acc[6:0], 1'b0};
   assign offset  = {{8{item.operand[7]}}, item.operand};
   assign target  = item.next_pc + offset;

   always_comb begin
      acc_next   = acc;
      flags_next = flags;
      is_branch  = 1'b0;
      take       = 1'b0;
      result     = '0;
      unique case (kind_type'(item.kind))
         KIND_ADC, KIND_SBC: begin
            acc_next     = sum[7:0];
            flags_next.c = sum[8];
            flags_next.v = ~(acc[7] ^ addend[7]) & (acc[7] ^ sum[7]);
            flags_next.z = (sum[7:0] == 8'd0);
            flags_next.n = sum[7];
         end
         KIND_AND: begin
            acc_next     = acc & item.operand;
            flags_next.z = ((acc & item.operand) == 8'd0);
            flags_next.n = acc[7] & item.operand[7];
         end
         KIND_ASL_ACC: begin
            acc_next     = shifted;
            flags_next.c = acc[7];
            flags_next.z = (shifted == 8'd0);
            flags_next.n = shifted[7];
         end
         KIND_ASL_MEM: begin
            flags_next.c         = item.operand[7];
            flags_next.z         = (shifted == 8'd0);
            flags_next.n         = shifted[7];
            result.write_enable  = 1'b1;
            result.write_address = item.target_address;
            result.write_data    = shifted;
         end
         KIND_BIT: begin
            flags_next.z = ((acc & item.operand) == 8'd0);
            flags_next.n = item.operand[7];
            flags_next.v = item.operand[6];
         end
         KIND_BCC: begin
            is_branch = 1'b1;
            take      = ~flags.c;
         end
         KIND_BCS: begin
            is_branch = 1'b1;
            take      = flags.c;
         end
         KIND_BEQ: begin
            is_branch = 1'b1;
            take      = flags.z;
         end
         KIND_BNE: begin
            is_branch = 1'b1;
            take      = ~flags.z;
         end
         KIND_BPL: begin
            is_branch = 1'b1;
            take      = ~flags.n;
         end
         default: begin
            is_branch = 1'b0;
         end
      endcase

      result.accumulator_out = acc_next;
      result.status_out      = status_byte(flags_next);
      if (is_branch && take) begin
         result.new_pc       = target;
         result.extra_cycles = (target[15:8] != item.next_pc[15:8]) ? EXTRA_CROSS_PAGE
                                                                     : EXTRA_SAME_PAGE;
      end else begin
         result.new_pc       = item.next_pc;
         result.extra_cycles = EXTRA_NONE;
      end
   end

endmodule

@@ sv/alu_flags_branch_unit_core.sv @@
// A result passes through the input register and then the result register before it is offered.
// Throughput: one item per cycle while rsp_stall is low; the accumulator and flags feed straight back.
// While a result waits, a new input transfer is taken only if the input register is empty.
// Reset (synchronous, active high) empties both stages and clears the accumulator and all flags.
// Top level of the ALU, flags and branch execute unit.
module alu_flags_branch_unit_core
   import afbu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   // Input stage: holds one accepted item until the execute step can run.
   logic       in_valid_ff;
   logic       in_valid_in;
   req_type    in_item_ff;

   // Architectural state, updated when an item executes.
   logic [7:0] acc_ff;
   logic [7:0] acc_in;
   flags_type  flags_ff;
   flags_type  flags_in;

   // Result stage.
   logic       out_valid_ff;
   logic       out_valid_in;
   rsp_type    out_item_ff;
   rsp_type    exec_result;

   logic       out_free;
   logic       exec_go;
   logic       req_take;

   // The result register can take a new result when it is empty or its transfer happens now.
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign exec_go   = in_valid_ff & out_free;
   // The input register can take a transfer when it is empty or its item executes now.
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   afbu_exec u_exec (
      .item       (in_item_ff),
      .acc        (acc_ff),
      .flags      (flags_ff),
      .acc_next   (acc_in),
      .flags_next (flags_in),
      .result     (exec_result)
   );

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~exec_go);
      out_valid_in = exec_go | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (exec_go) begin
            acc_ff   <= acc_in;
            flags_ff <= flags_in;
         end
      end
   end

   // Payload registers load only on a move, so a stalled result stays put.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (exec_go) begin
         out_item_ff <= exec_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the ALU, flags and branch execute unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import afbu_pkg::*;

   // Kind codes that the unit treats as no operation.
   localparam logic [3:0] KIND_UNUSED_LO = 4'd11;
   localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

   // Number of random items after the directed opening.
   localparam int RANDOM_ITEMS = 1150;
   // The receiver holds off once for this many cycles after this many results.
   localparam int HOLD_AFTER_RESULTS = 400;
   localparam int HOLD_CYCLES        = 300;
   // Cycles allowed after the last result for a stray transfer to show up.
   localparam int SETTLE_CYCLES      = 10;

   // One instruction waiting to be offered. When drain_first is set the
   // sender holds it back until every result in flight has come out.
   typedef struct {
      req_type item;
      bit      drain_first;
   } program_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   program_entry_type program_items[$];
   rsp_type           executed_results[$];

   // Architectural state as the testbench expects it to be.
   logic [7:0] shadow_acc   = 8'h00;
   flags_type  shadow_flags = '0;

   int fail_count   = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int burst_left   = 1;
   int gap_left     = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   alu_flags_branch_unit_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Executes one instruction on the shadow state and returns the result
   // transfer that the unit should produce for it.
   function automatic rsp_type execute_op(input req_type r);
      rsp_type     o;
      logic [7:0]  m;
      logic [7:0]  res;
      logic [8:0]  sum;
      logic [15:0] offset;
      logic        is_branch;
      logic        take;
      o         = '0;
      o.new_pc  = r.next_pc;
      is_branch = 1'b0;
      take      = 1'b0;
      case (r.kind)
         KIND_ADC, KIND_SBC: begin
            // Subtraction is addition of the inverted operand, so the carry
            // acts as the inverse of a borrow.
            m   = (r.kind == KIND_SBC) ? ~r.operand : r.operand;
            sum = {1'b0, shadow_acc} + {1'b0, m} + {8'h00, shadow_flags.c};
            res = sum[7:0];
            shadow_flags.c = sum[8];
            shadow_flags.v = ~(shadow_acc[7] ^ m[7]) & (shadow_acc[7] ^ res[7]);
            shadow_flags.z = (res == 8'h00);
            shadow_flags.n = res[7];
            shadow_acc     = res;
         end
         KIND_AND: begin
            shadow_acc     = shadow_acc & r.operand;
            shadow_flags.z = (shadow_acc == 8'h00);
            shadow_flags.n = shadow_acc[7];
         end
         KIND_ASL_ACC: begin
            shadow_flags.c = shadow_acc[7];
            shadow_acc     = {shadow_acc[6:0], 1'b0};
            shadow_flags.z = (shadow_acc == 8'h00);
            shadow_flags.n = shadow_acc[7];
         end
         KIND_ASL_MEM: begin
            // The accumulator stays; the flags follow the shifted byte.
            shadow_flags.c  = r.operand[7];
            o.write_data    = {r.operand[6:0], 1'b0};
            shadow_flags.z  = (o.write_data == 8'h00);
            shadow_flags.n  = o.write_data[7];
            o.write_enable  = 1'b1;
            o.write_address = r.target_address;
         end
         KIND_BIT: begin
            shadow_flags.z = ((shadow_acc & r.operand) == 8'h00);
            shadow_flags.n = r.operand[7];
            shadow_flags.v = r.operand[6];
         end
         KIND_BCC: begin
            is_branch = 1'b1;
            take      = !shadow_flags.c;
         end
         KIND_BCS: begin
            is_branch = 1'b1;
            take      = shadow_flags.c;
         end
         KIND_BEQ: begin
            is_branch = 1'b1;
            take      = shadow_flags.z;
         end
         KIND_BNE: begin
            is_branch = 1'b1;
            take      = !shadow_flags.z;
         end
         KIND_BPL: begin
            is_branch = 1'b1;
            take      = !shadow_flags.n;
         end
         default: begin
         end
      endcase
      if (is_branch && take) begin
         // Sign-extended offset; the sum wraps at 16 bits.
         offset         = {{8{r.operand[7]}}, r.operand};
         o.new_pc       = r.next_pc + offset;
         o.extra_cycles = (o.new_pc[15:8] != r.next_pc[15:8]) ? EXTRA_CROSS_PAGE
                                                               : EXTRA_SAME_PAGE;
      end
      o.accumulator_out             = shadow_acc;
      o.status_out                  = 8'h00;
      o.status_out[FLAG_C_BIT]      = shadow_flags.c;
      o.status_out[FLAG_Z_BIT]      = shadow_flags.z;
      o.status_out[FLAG_V_BIT]      = shadow_flags.v;
      o.status_out[FLAG_N_BIT]      = shadow_flags.n;
      return o;
   endfunction

   function automatic void add_item(input logic [3:0] kind, input logic [7:0] operand,
                                    input logic [15:0] next_pc,
                                    input logic [15:0] target_address,
                                    input bit drain_first);
      program_entry_type e;
      e.item.kind           = kind;
      e.item.operand        = operand;
      e.item.next_pc        = next_pc;
      e.item.target_address = target_address;
      e.drain_first         = drain_first;
      program_items.push_back(e);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Random byte that lands on one of the sign and carry boundaries now and then.
   function automatic logic [7:0] random_byte();
      logic [7:0] corners[4];
      corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      if ($urandom_range(0, 7) == 0)
         return corners[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   // Random program counter, often near a page edge so that branches cross.
   function automatic logic [15:0] random_pc();
      logic [15:0] pc;
      pc = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
         0: pc[7:0] = 8'($urandom_range(0, 3));
         1: pc[7:0] = 8'($urandom_range(8'hFC, 8'hFF));
         default: begin
         end
      endcase
      return pc;
   endfunction

   // Sender. It works in bursts with gaps between them. A payload that has
   // been offered stays put until its transfer, and a drain entry waits for
   // every result in flight before it is offered.
   always @(posedge clock) begin
      logic              accepted;
      logic              next_valid;
      req_type           next_item;
      program_entry_type entry;
      accepted   = req_valid && !req_stall;
      next_valid = req_valid;
      next_item  = req_item;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (accepted) begin
            executed_results.push_back(execute_op(req_item));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (program_items.size() != 0 &&
                         !(program_items[0].drain_first && executed_results.size() != 0)) begin
               entry      = program_items.pop_front();
               next_item  = entry.item;
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_item  <= next_item;
   end

   // Receiver. Every result transfer is checked against the oldest
   // prediction. The stall pattern rotates between no stalls, random stalls
   // and a fixed duty cycle, with one long hold-off that fills the unit.
   always @(posedge clock) begin
      rsp_type want;
      logic    next_stall;
      cycle_count++;
      next_stall = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (executed_results.size() == 0) begin
               $error("result transfer with no prediction waiting: %p", rsp_item);
               fail_count++;
            end else begin
               want = executed_results.pop_front();
               check_field("accumulator_out", 16'(want.accumulator_out),
                           16'(rsp_item.accumulator_out));
               check_field("status_out", 16'(want.status_out), 16'(rsp_item.status_out));
               check_field("new_pc", want.new_pc, rsp_item.new_pc);
               check_field("write_enable", 16'(want.write_enable),
                           16'(rsp_item.write_enable));
               check_field("write_address", want.write_address, rsp_item.write_address);
               check_field("write_data", 16'(want.write_data), 16'(rsp_item.write_data));
               check_field("extra_cycles", 16'(want.extra_cycles),
                           16'(rsp_item.extra_cycles));
            end
            results_seen++;
         end
         if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            case ((cycle_count / 400) % 3)
               0: next_stall = 1'b0;
               1: next_stall = ($urandom_range(0, 3) == 0);
               default: next_stall = ((cycle_count % 7) < 3);
            endcase
         end
      end
      rsp_stall <= next_stall;
   end

   // Program, reset and end of run.
   initial begin
      logic [3:0] kind;

      // Directed opening: carry and overflow edges of add and subtract,
      // every operation, page crossing and wrap of branch targets, the
      // memory shift at both address extremes, and the unused kinds.
      add_item(KIND_ADC, 8'hFF, 16'h0000, 16'h0000, 1'b0);
      add_item(KIND_ADC, 8'h01, 16'h0010, 16'h0000, 1'b0);
      add_item(KIND_BCS, 8'h7F, 16'h00F0, 16'h0000, 1'b0);
      add_item(KIND_BCC, 8'h10, 16'h0200, 16'h0000, 1'b0);
      add_item(KIND_BEQ, 8'h80, 16'h0000, 16'h0000, 1'b0);
      add_item(KIND_BNE, 8'h05, 16'h1234, 16'h0000, 1'b0);
      add_item(KIND_ADC, 8'h7F, 16'h0300, 16'h0000, 1'b0);
      add_item(KIND_SBC, 8'h01, 16'h0301, 16'h0000, 1'b0);
      add_item(KIND_SBC, 8'h00, 16'h0302, 16'h0000, 1'b0);
      add_item(KIND_SBC, 8'hFF, 16'h0303, 16'h0000, 1'b0);
      add_item(KIND_SBC, 8'h80, 16'h0304, 16'h0000, 1'b0);
      add_item(KIND_AND, 8'hFF, 16'h0305, 16'h0000, 1'b0);
      add_item(KIND_AND, 8'h00, 16'h0306, 16'h0000, 1'b0);
      add_item(KIND_BEQ, 8'h05, 16'h1234, 16'h0000, 1'b0);
      add_item(KIND_BNE, 8'h05, 16'h1234, 16'h0000, 1'b0);
      add_item(KIND_ADC, 8'hC0, 16'h0400, 16'h0000, 1'b0);
      add_item(KIND_ASL_ACC, 8'h00, 16'h0401, 16'h0000, 1'b0);
      add_item(KIND_ASL_ACC, 8'hFF, 16'h0402, 16'h0000, 1'b0);
      add_item(KIND_ASL_MEM, 8'h80, 16'h0403, 16'hFFFF, 1'b0);
      add_item(KIND_ASL_MEM, 8'h41, 16'h0404, 16'h0000, 1'b0);
      add_item(KIND_BPL, 8'hF0, 16'h0405, 16'h0000, 1'b0);
      add_item(KIND_BIT, 8'hC0, 16'h0406, 16'h0000, 1'b0);
      add_item(KIND_BPL, 8'h10, 16'h0407, 16'h0000, 1'b0);
      add_item(KIND_BIT, 8'h3F, 16'h0408, 16'h0000, 1'b0);
      add_item(KIND_BPL, 8'h80, 16'hFF90, 16'h0000, 1'b0);
      add_item(KIND_UNUSED_LO, 8'hAA, 16'h5555, 16'hAAAA, 1'b0);
      add_item(KIND_UNUSED_HI, 8'h55, 16'hAAAA, 16'h5555, 1'b0);

      // Random part. Most kinds are real operations; a few are unused codes.
      // The first random item, one in the middle and a sprinkling of others
      // wait until the unit has drained completely.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 19) != 0)
            kind = 4'($urandom_range(KIND_ADC, KIND_BPL));
         else
            kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         add_item(kind, random_byte(), random_pc(), 16'($urandom_range(0, 65535)),
                  (i == 0) || (i == RANDOM_ITEMS / 2) || ($urandom_range(0, 99) == 0));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Sampling on the falling edge sees settled values from both sides.
      do @(negedge clock);
      while (program_items.size() != 0 || req_valid || executed_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
sv/afbu_pkg.sv
sv/afbu_exec.sv
sv/alu_flags_branch_unit_core.sv
test/tb_top.sv
